// ----- design/generational_handle_table_top_defines.svh -----
// Assertion macros shared by the handle table RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH

// Plain property checked on every clock edge outside reset.
`define GHT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("handle table assertion failed");

// Same-cycle implication.
`define GHT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("handle table implication failed");

// Next-cycle implication.
`define GHT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("handle table next-cycle check failed");

`endif

// ----- design/ght_pkg.sv -----
// Package of the generational handle table: entry layout, operation and status codes,
// the evaluation result bundle and the generation advance function. No dependencies.
`default_nettype none

package ght_pkg;

	localparam logic [31:0] HANDLE_NONE = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_BAD   = 3'd1,
		ST_FULL  = 3'd2,
		ST_STALE = 3'd3,
		ST_KIND  = 3'd4
	} status_t;

	typedef struct packed {
		logic        used;
		logic [15:0] gen;
		logic [31:0] pointer;
		logic [1:0]  kind;
	} entry_t;

	typedef struct packed {
		logic        take;
		logic        wr;
		status_t     status;
		logic [31:0] pointer;
		entry_t      wdata;
	} eval_t;

	function automatic logic [15:0] next_gen(input logic [15:0] g);
		logic [15:0] n;
		n = g + 16'd1;
		return (n == 16'd0) ? 16'd1 : n;
	endfunction

endpackage

`default_nettype wire

// ----- design/ght_if.sv -----
// Request and response channel interfaces of the handle table.
// Valid/ready handshake; a transaction completes when both are high. No dependencies.
`default_nettype none

interface ght_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] handle;
	logic [31:0] obj_pointer;
	logic [1:0]  obj_type;

	modport source(output valid, op, handle, obj_pointer, obj_type, input ready);
	modport sink(input valid, op, handle, obj_pointer, obj_type, output ready);
endinterface

interface ght_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] out_handle;
	logic [31:0] out_pointer;

	modport source(output valid, status, out_handle, out_pointer, input ready);
	modport sink(input valid, status, out_handle, out_pointer, output ready);
endinterface

`default_nettype wire

// ----- design/ght_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/ght_eval.sv -----
// Shared check unit: compares one stored entry with the pending request and
// forms the status, the returned pointer and the entry write-back. Uses ght_pkg.
`default_nettype none

module ght_eval (
	input  wire ght_pkg::op_t   op,
	input  wire ght_pkg::entry_t ent,
	input  wire logic [15:0]    hgen,
	input  wire logic [31:0]    obj_pointer,
	input  wire logic [1:0]     obj_type,
	output ght_pkg::eval_t      res
);
	import ght_pkg::*;

	logic match;

	assign match = ent.used && (ent.gen == hgen);

	always_comb begin
		res         = '0;
		res.status  = ST_BAD;
		res.wdata   = ent;
		case (op)
			OP_ALLOC: begin
				res.take          = !ent.used;
				res.wr            = !ent.used;
				res.status        = ST_OK;
				res.wdata.used    = 1'b1;
				res.wdata.gen     = next_gen(ent.gen);
				res.wdata.pointer = obj_pointer;
				res.wdata.kind    = obj_type;
			end
			OP_LOOKUP: begin
				if (!match) begin
					res.status = ST_STALE;
				end else if (ent.kind != obj_type) begin
					res.status = ST_KIND;
				end else begin
					res.status  = ST_OK;
					res.pointer = ent.pointer;
				end
			end
			OP_RELEASE: begin
				if (!match) begin
					res.status = ST_STALE;
				end else begin
					res.status        = ST_OK;
					res.wr            = 1'b1;
					res.wdata.used    = 1'b0;
					res.wdata.gen     = next_gen(ent.gen);
					res.wdata.pointer = '0;
					res.wdata.kind    = '0;
				end
			end
			default: begin
				res.status = ST_BAD;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/generational_handle_table_top.sv -----
// Top level: sequencer, entry RAM and shared check unit of the handle table.
// A request that reads the table goes from idle through the read, evaluate and hold states;
// an allocate reads and evaluates the next entry once more for each used entry it skips above
// the lowest-free hint. Rejects that need no read go from idle straight to hold. Hold registers
// the result once the response register is free, and the next request can then be taken.
// After reset a clearing pass writes all SLOTS entries, one per cycle. Uses ght_pkg, ght_if.
`default_nettype none
`include "generational_handle_table_top_defines.svh"

module generational_handle_table_top #(
	parameter int SLOTS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	ght_req_if.sink  req,
	ght_rsp_if.source rsp
);
	import ght_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = $bits(entry_t);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
	localparam logic [16:0] SLOTS_H = 17'(SLOTS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_HOLD
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   idx_q;
	logic [CW-1:0]   low_free_q;
	op_t             op_q;
	logic [15:0]     hgen_q;
	logic [31:0]     ptr_q;
	logic [1:0]      kind_q;
	status_t         res_status_q;
	logic [31:0]     res_handle_q;
	logic [31:0]     res_ptr_q;
	logic            ov_q;
	status_t         ostat_q;
	logic [31:0]     ohandle_q;
	logic [31:0]     optr_q;

	logic            ram_wr_en;
	logic [IW-1:0]   ram_wr_addr;
	entry_t          ram_wr_data;
	logic            ram_rd_en;
	logic [IW-1:0]   ram_rd_addr;
	logic [EW-1:0]   ram_rd_data;
	entry_t          ent;
	eval_t           ev;
	logic            scan_on;
	logic            in_range;
	logic            out_free;

	assign ent      = entry_t'(ram_rd_data);
	assign in_range = ({1'b0, req.handle[15:0]} < SLOTS_H);
	assign out_free = !ov_q || rsp.ready;
	assign scan_on  = (state_q == S_EVAL) && (op_q == OP_ALLOC) && !ev.take
		&& (idx_q != LAST_IDX);

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = ov_q;
	assign rsp.status      = ostat_q;
	assign rsp.out_handle  = ohandle_q;
	assign rsp.out_pointer = optr_q;

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = idx_q;
		ram_wr_data = ev.wdata;
		ram_rd_en   = 1'b0;
		ram_rd_addr = idx_q;
		case (state_q)
			S_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_data = '0;
			end
			S_READ: begin
				ram_rd_en = 1'b1;
			end
			S_EVAL: begin
				ram_wr_en   = ev.wr;
				ram_rd_en   = scan_on;
				ram_rd_addr = idx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	ght_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(EW'(ram_wr_data)),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	ght_eval u_eval (
		.op         (op_q),
		.ent        (ent),
		.hgen       (hgen_q),
		.obj_pointer(ptr_q),
		.obj_type   (kind_q),
		.res        (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			idx_q      <= '0;
			low_free_q <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (ov_q && rsp.ready && (state_q != S_HOLD)) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q         <= op_t'(req.op);
						hgen_q       <= req.handle[31:16];
						ptr_q        <= req.obj_pointer;
						kind_q       <= req.obj_type;
						res_status_q <= ST_BAD;
						res_handle_q <= HANDLE_NONE;
						res_ptr_q    <= '0;
						state_q      <= S_HOLD;
						case (op_t'(req.op))
							OP_ALLOC: begin
								if (req.obj_pointer == 32'd0) begin
									res_status_q <= ST_BAD;
								end else if (low_free_q == SLOTS_C) begin
									res_status_q <= ST_FULL;
								end else begin
									idx_q   <= low_free_q[IW-1:0];
									state_q <= S_READ;
								end
							end
							OP_LOOKUP, OP_RELEASE: begin
								if (req.handle != HANDLE_NONE && in_range) begin
									idx_q   <= req.handle[IW-1:0];
									state_q <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (op_q == OP_ALLOC) begin
						if (ev.take) begin
							res_status_q <= ST_OK;
							res_handle_q <= {ev.wdata.gen, 16'(idx_q)};
							low_free_q   <= CW'(idx_q) + 1'b1;
							state_q      <= S_HOLD;
						end else if (scan_on) begin
							idx_q <= idx_q + 1'b1;
						end else begin
							res_status_q <= ST_FULL;
							low_free_q   <= SLOTS_C;
							state_q      <= S_HOLD;
						end
					end else begin
						res_status_q <= ev.status;
						res_ptr_q    <= ev.pointer;
						if (ev.wr && (CW'(idx_q) < low_free_q)) begin
							low_free_q <= CW'(idx_q);
						end
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						ov_q      <= 1'b1;
						ostat_q   <= res_status_q;
						ohandle_q <= res_handle_q;
						optr_q    <= res_ptr_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`GHT_ASSERT(a_hint_range, low_free_q <= SLOTS_C)
	`GHT_IMPLY(a_wr_state, ram_wr_en, (state_q == S_CLEAR) || (state_q == S_EVAL))
	`GHT_IMPLY(a_fail_handle, ov_q && (ostat_q != ST_OK), ohandle_q == HANDLE_NONE)
	`GHT_IMPLY(a_ptr_ok, ov_q && (optr_q != 32'd0), ostat_q == ST_OK)
	`GHT_NEXT(a_scan_step, scan_on, (state_q == S_EVAL) && (idx_q != '0))

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for generational_handle_table_top: directed and random
// allocate, look up and release traffic under varying idle and stall patterns.
// Depends on ght_pkg, ght_req_if and ght_rsp_if from the design folder.
`default_nettype none

module testbench;
	import ght_pkg::*;

	localparam int SLOTS = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 330;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] handle;
		logic [31:0] obj_pointer;
		logic [1:0]  obj_type;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] out_handle;
		logic [31:0] out_pointer;
	} reply_t;

	logic clk;
	logic arst_n;
	logic hold_off;
	logic hold_armed;
	int send_idle_pct;
	int stall_pct;
	int errors;

	logic        table_used [SLOTS];
	logic [15:0] table_gen  [SLOTS];
	logic [31:0] table_ptr  [SLOTS];
	logic [1:0]  table_kind [SLOTS];

	request_t    requests_to_send[$];
	reply_t      replies_planned[$];
	reply_t      replies_due[$];
	logic [31:0] retired[$];

	ght_req_if req_ch();
	ght_rsp_if rsp_ch();

	generational_handle_table_top #(.SLOTS(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = '0;
		req_ch.handle = '0;
		req_ch.obj_pointer = '0;
		req_ch.obj_type = '0;
		rsp_ch.ready = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 4_000_000);
		$display("FAIL generational_handle_table_top");
		$finish;
	end

	initial begin
		hold_off = 1'b0;
		wait (hold_armed);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic logic [15:0] advance_gen(input logic [15:0] g);
		return (g == 16'hFFFF) ? 16'd1 : g + 16'd1;
	endfunction

	function automatic status_t handle_status(input logic [31:0] handle);
		logic [15:0] idx;
		idx = handle[15:0];
		if (handle == HANDLE_NONE || idx >= SLOTS)
			return ST_BAD;
		if (!table_used[idx] || table_gen[idx] != handle[31:16])
			return ST_STALE;
		return ST_OK;
	endfunction

	function automatic logic [31:0] live_handle(input int slot);
		return {table_gen[slot], 16'(slot)};
	endfunction

	function automatic reply_t apply_request(input request_t rq);
		reply_t rp;
		logic found;
		logic [15:0] idx;
		rp.status = ST_BAD;
		rp.out_handle = HANDLE_NONE;
		rp.out_pointer = '0;
		idx = rq.handle[15:0];
		found = 1'b0;
		case (rq.op)
			OP_ALLOC: begin
				if (rq.obj_pointer != '0) begin
					rp.status = ST_FULL;
					for (int i = 0; i < SLOTS; i++) begin
						if (!found && !table_used[i]) begin
							found = 1'b1;
							table_gen[i] = advance_gen(table_gen[i]);
							table_ptr[i] = rq.obj_pointer;
							table_kind[i] = rq.obj_type;
							table_used[i] = 1'b1;
							rp.out_handle = live_handle(i);
							rp.status = ST_OK;
						end
					end
				end
			end
			OP_LOOKUP: begin
				rp.status = handle_status(rq.handle);
				if (rp.status == ST_OK) begin
					if (table_kind[idx] != rq.obj_type)
						rp.status = ST_KIND;
					else
						rp.out_pointer = table_ptr[idx];
				end
			end
			OP_RELEASE: begin
				rp.status = handle_status(rq.handle);
				if (rp.status == ST_OK) begin
					table_used[idx] = 1'b0;
					table_ptr[idx] = '0;
					table_kind[idx] = '0;
					table_gen[idx] = advance_gen(table_gen[idx]);
				end
			end
			default: rp.status = ST_BAD;
		endcase
		return rp;
	endfunction

	task automatic submit(input logic [1:0] op, input logic [31:0] handle,
			input logic [31:0] obj_pointer, input logic [1:0] obj_type);
		request_t rq;
		reply_t rp;
		rq.op = op;
		rq.handle = handle;
		rq.obj_pointer = obj_pointer;
		rq.obj_type = obj_type;
		rp = apply_request(rq);
		if (op == OP_RELEASE && rp.status == ST_OK) begin
			retired.push_back(handle);
			if (retired.size() > 32)
				void'(retired.pop_front());
		end
		requests_to_send.push_back(rq);
		replies_planned.push_back(rp);
	endtask

	task automatic random_request(input int alloc_pct);
		int live[$];
		int pick;
		int slot;
		logic [1:0] kind;
		logic [1:0] op;
		logic [31:0] handle;
		for (int i = 0; i < SLOTS; i++)
			if (table_used[i])
				live.push_back(i);
		pick = $urandom_range(99);
		op = ($urandom_range(9) < 6) ? OP_LOOKUP : OP_RELEASE;
		kind = 2'($urandom_range(3));
		if (pick < alloc_pct) begin
			submit(OP_ALLOC, $urandom, ($urandom_range(15) == 0) ? 32'd0 : $urandom, kind);
		end else if (pick < alloc_pct + 8) begin
			submit(2'($urandom_range(3)), $urandom, $urandom, kind);
		end else if (pick < alloc_pct + 14) begin
			handle = {16'($urandom), 16'($urandom_range(SLOTS, 16'hFFFF))};
			submit(op, handle, $urandom, kind);
		end else if (pick < alloc_pct + 24 || live.size() == 0) begin
			if (retired.size() != 0)
				handle = retired[$urandom_range(retired.size() - 1)];
			else
				handle = {16'($urandom), 16'($urandom_range(SLOTS - 1))};
			submit(op, handle, $urandom, kind);
		end else begin
			slot = live[$urandom_range(live.size() - 1)];
			if ($urandom_range(4) != 0)
				kind = table_kind[slot];
			submit(op, live_handle(slot), $urandom, kind);
		end
	endtask

	task automatic drain();
		while (requests_to_send.size() != 0 || req_ch.valid || replies_planned.size() != 0
				|| replies_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 100)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin : request_driver
		request_t rq;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= '0;
			req_ch.handle <= '0;
			req_ch.obj_pointer <= '0;
			req_ch.obj_type <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid)
				replies_due.push_back(replies_planned.pop_front());
			if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				rq = requests_to_send.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.op <= rq.op;
				req_ch.handle <= rq.handle;
				req_ch.obj_pointer <= rq.obj_pointer;
				req_ch.obj_type <= rq.obj_type;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : response_check
		reply_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch("response with no transaction outstanding");
				end else begin
					want = replies_due.pop_front();
					if (rsp_ch.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp_ch.status, want.status));
					if (rsp_ch.out_handle !== want.out_handle)
						report_mismatch($sformatf("out_handle %h, expected %h",
							rsp_ch.out_handle, want.out_handle));
					if (rsp_ch.out_pointer !== want.out_pointer)
						report_mismatch($sformatf("out_pointer %h, expected %h",
							rsp_ch.out_pointer, want.out_pointer));
				end
			end
			rsp_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin : stimulus
		int idle_set[4];
		int stall_set[4];
		logic [1:0] kind;
		errors = 0;
		hold_armed = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		idle_set = '{0, 74, 0, 30};
		stall_set = '{0, 0, 74, 30};
		for (int i = 0; i < SLOTS; i++) begin
			table_used[i] = 1'b0;
			table_gen[i] = '0;
			table_ptr[i] = '0;
			table_kind[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A null pointer is refused, then two entries are taken.
		submit(OP_ALLOC, HANDLE_NONE, 32'd0, 2'd1);
		submit(OP_ALLOC, '0, 32'hFFFF_FFFF, 2'd3);
		submit(OP_ALLOC, HANDLE_NONE, 32'd1, 2'd0);
		submit(OP_LOOKUP, live_handle(0), '0, 2'd3);
		submit(OP_LOOKUP, live_handle(0), 32'hFFFF_FFFF, 2'd0);
		submit(OP_LOOKUP, HANDLE_NONE, '0, 2'd3);
		submit(OP_LOOKUP, {16'd1, 16'(SLOTS)}, '0, 2'd3);
		submit(OP_LOOKUP, 32'h0001_FFFF, '0, 2'd3);
		submit(OP_LOOKUP, {16'd2, 16'd0}, '0, 2'd3);
		submit(OP_LOOKUP, {16'd0, 16'd5}, '0, 2'd0);
		submit(OP_LOOKUP, 32'h0000_0000, '0, 2'd0);
		submit(OP_RELEASE, live_handle(1), '0, 2'd3);
		submit(OP_RELEASE, {16'd1, 16'd1}, '0, 2'd0);
		submit(OP_LOOKUP, {16'd1, 16'd1}, '0, 2'd0);
		submit(OP_UNUSED, live_handle(0), 32'h1234_5678, 2'd3);
		submit(OP_RELEASE, HANDLE_NONE, '0, 2'd0);
		submit(OP_RELEASE, {16'd1, 16'(SLOTS)}, '0, 2'd0);
		submit(OP_ALLOC, '0, 32'h8000_0000, 2'd2);
		submit(OP_LOOKUP, live_handle(1), '0, 2'd2);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_request(((n / 40) % 2 == 0) ? 65 : 15);
			if (p == 0)
				hold_armed = 1'b1;
			drain();
		end

		// Empty the table, then take the lowest entry again and look it up.
		send_idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < SLOTS; i++)
			if (table_used[i])
				submit(OP_RELEASE, live_handle(i), $urandom, 2'($urandom_range(3)));
		kind = 2'($urandom_range(3));
		submit(OP_ALLOC, '0, 32'hCAFE_0001, kind);
		submit(OP_LOOKUP, live_handle(0), '0, kind);
		submit(OP_LOOKUP, {16'hFFFF, 16'd0}, '0, kind);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS generational_handle_table_top");
		else
			$display("FAIL generational_handle_table_top");
		$finish;
	end

endmodule

`default_nettype wire
